// ===== rtl/soil_heat_flux_per_pixel_unit_defines.svh =====
// Assertion macros for the soil heat flux pixel unit.
// Define NO_ASSERTIONS to compile the assertions out.
`ifndef SOIL_HEAT_FLUX_PER_PIXEL_UNIT_DEFINES_SVH
`define SOIL_HEAT_FLUX_PER_PIXEL_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SHF_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("soil heat flux unit: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("soil heat flux unit: assertion failed");

`else

`define SHF_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define SHF_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/shf_pkg.sv =====
`default_nettype none

package shf_pkg;

    // Field widths.
    localparam int unsigned NdviW  = 16;
    localparam int unsigned TempW  = 15;
    localparam int unsigned AlbW   = 16;
    localparam int unsigned RadW   = 15;
    localparam int unsigned HeatW  = 15;

    // Number of register stages from input to output.
    localparam int unsigned Stages = 8;

    // Temperature term: d = 20 * (5*t - 87408); positive only for t above 17481.
    localparam logic [17:0] T_OFFSET  = 18'd87408;
    localparam logic [14:0] T_ZERO_MAX = 15'd17481;

    // Albedo term: b = 2 * (1245184 + 37*a).
    localparam logic [21:0] B_OFFSET = 22'd1245184;
    localparam logic [5:0]  B_SLOPE  = 6'd37;

    // Reciprocal of 3125 for a dividend below 2^27: q = (x * M) >> 39.
    localparam logic [27:0] RCP3125_A    = 28'd175921861;
    localparam int unsigned RCP3125_A_SH = 39;

    // Reciprocal of 3125 for a dividend below 2^28: q = (x * M) >> 40.
    localparam logic [28:0] RCP3125_B    = 29'd351843721;
    localparam int unsigned RCP3125_B_SH = 40;

    // Reciprocal of 25 for a dividend below 2^30: q = (x * M) >> 35.
    localparam logic [30:0] RCP25    = 31'd1374389535;
    localparam int unsigned RCP25_SH = 35;

    localparam logic [11:0] DIV3125 = 12'd3125;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [47:0] ROUND_Q30 = 48'h0000_2000_0000;
    localparam logic [HeatW-1:0] G_MAX = 15'h7FFF;

endpackage

`default_nettype wire

// ===== rtl/soil_heat_flux_per_pixel_unit.sv =====
// Soil heat flux per pixel.
// Input channel: i_valid / o_ready with NDVI (Q1.15), surface temperature
// (1/64 K), albedo (Q0.16), net radiation (1/16 W/m2) and a last-pixel flag.
// Output channel: o_valid / i_ready with soil heat flux (1/16 W/m2) and the
// copied last-pixel flag. A request is taken when valid and ready are high.
// The unit is an eight-stage pipeline: a request accepted at a clock edge
// moves through the stage registers in order and shows its result from the
// last one, where the receiver takes it when valid and ready are high.
// Throughput is one pixel per cycle unless the receiver stalls; the multiplier
// chain of temperature and albedo terms sets the depth, at most three per stage.
// Negative NDVI gives half the net radiation, rounded half up; temperatures at
// or below 273.15 K give zero; large results saturate at 32767.
// When the receiver holds i_ready low while a result waits, the whole pipeline
// freezes and o_ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline; the first request may
// be offered in the cycle after reset is released.
`default_nettype none

`include "soil_heat_flux_per_pixel_unit_defines.svh"

module soil_heat_flux_per_pixel_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [shf_pkg::NdviW-1:0]     i_ndvi,
    input  wire logic [shf_pkg::TempW-1:0]     i_surface_temp,
    input  wire logic [shf_pkg::AlbW-1:0]      i_albedo,
    input  wire logic [shf_pkg::RadW-1:0]      i_net_radiation,
    input  wire logic                          i_last_pixel,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [shf_pkg::HeatW-1:0]          o_soil_heat,
    output logic                               o_last_pixel_out
);

    import shf_pkg::*;

    // Pipeline advance: the output register is free or is being drained.
    logic w_adv;
    logic [Stages:1] r_v;

    assign w_adv   = ~r_v[Stages] | i_ready;
    assign o_ready = w_adv;

    // Control and pass-through fields, one copy per stage.
    logic [Stages-1:1] r_neg;
    logic [Stages-1:1] r_tpos;
    logic [Stages:1]   r_last;
    logic [14:0]       r_half [1:Stages-1];
    logic [RadW-1:0]   r_rad  [1:Stages-1];

    // Stage 1 datapath.
    logic [29:0] r1_n2;
    logic [16:0] r1_dp;
    logic [26:0] r1_x1;
    logic [17:0] w_t5;
    logic [21:0] w_bp;
    logic [15:0] w_rp1;

    // Later stage datapath.
    logic [29:0] r2_p4;
    logic [15:0] r2_qb;
    logic [26:0] r2_x1;
    logic [16:0] r2_dp;
    logic [59:0] w_n4;
    logic [54:0] w_qa;

    logic [11:0] r3_rb;
    logic [25:0] r3_q25;
    logic [29:0] r3_p4;
    logic [15:0] r3_qb;
    logic [16:0] r3_dp;
    logic [26:0] w_rem;
    logic [30:0] w_p4r;
    logic [60:0] w_q25;

    logic [27:0] r4_x2;
    logic [31:0] r4_dq;
    logic [30:0] r4_veg;
    logic [28:0] w_x2;
    logic [32:0] w_dq;

    logic [16:0] r5_q2;
    logic [31:0] r5_dq;
    logic [30:0] r5_veg;
    logic [56:0] w_q2;

    logic [31:0] r6_ab;
    logic [30:0] r6_veg;
    logic [32:0] w_ab;

    logic [31:0] r7_abc;
    logic [62:0] w_abc;

    logic [47:0] w_gr;
    logic [17:0] w_g;
    logic [HeatW-1:0] w_heat;
    logic [HeatW-1:0] r8_heat;

    // Stage 1: square of the index, temperature and albedo terms.
    assign w_t5  = 18'(i_surface_temp) * 18'd5;
    assign w_bp  = B_OFFSET + 22'(i_albedo) * 22'(B_SLOPE);
    assign w_rp1 = 16'(i_net_radiation) + 16'd1;

    // Stage 2: fourth power and the quotient of 32*b' by 3125.
    assign w_n4 = 60'(r1_n2) * 60'(r1_n2);
    assign w_qa = 55'(r1_x1) * 55'(RCP3125_A);

    // Stage 3: remainder of 32*b' and the 1/50 share of the fourth power.
    assign w_rem = r2_x1 - 27'(r2_qb) * 27'(DIV3125);
    assign w_p4r = 31'(r2_p4) + 31'd24;
    assign w_q25 = 61'(w_p4r[30:1]) * 61'(RCP25);

    // Stage 4: split product of the temperature and albedo terms, and the
    // vegetation factor 2^30 - p4 + floor((p4 + 24) / 50).
    assign w_x2 = 29'(r3_dp) * 29'(r3_rb);
    assign w_dq = 33'(r3_dp) * 33'(r3_qb);

    // Stage 5: remainder share divided by 3125.
    assign w_q2 = 57'(r4_x2) * 57'(RCP3125_B);

    // Stage 6: combined temperature and albedo product.
    assign w_ab = 33'(r5_dq) + 33'(r5_q2);

    // Stage 7: apply the vegetation factor.
    assign w_abc = 63'(r6_ab) * 63'(r6_veg);

    // Stage 8: scale by net radiation, round half up, then pick the case.
    assign w_gr = 48'(r7_abc) * 48'(r_rad[Stages-1]) + ROUND_Q30;
    assign w_g  = w_gr[47:30];

    always_comb begin
        priority if (r_neg[Stages-1]) begin
            w_heat = r_half[Stages-1];
        end else if (!r_tpos[Stages-1]) begin
            w_heat = '0;
        end else if (w_g > 18'(G_MAX)) begin
            w_heat = G_MAX;
        end else begin
            w_heat = w_g[HeatW-1:0];
        end
    end

    // Valid bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[Stages-1:1], i_valid};
        end
    end

    // Payload registers; they move only when the pipeline advances.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_neg[1]  <= i_ndvi[NdviW-1];
            r_tpos[1] <= i_surface_temp > T_ZERO_MAX;
            r_last[1] <= i_last_pixel;
            r_half[1] <= w_rp1[15:1];
            r_rad[1]  <= i_net_radiation;
            r1_n2     <= 30'(i_ndvi[NdviW-2:0]) * 30'(i_ndvi[NdviW-2:0]);
            r1_dp     <= 17'(w_t5 - T_OFFSET);
            r1_x1     <= {w_bp, 5'd0};

            for (int k = 2; k <= Stages - 1; k++) begin
                r_neg[k]  <= r_neg[k-1];
                r_tpos[k] <= r_tpos[k-1];
                r_half[k] <= r_half[k-1];
                r_rad[k]  <= r_rad[k-1];
            end
            for (int k = 2; k <= Stages; k++) begin
                r_last[k] <= r_last[k-1];
            end

            r2_p4 <= w_n4[59:30];
            r2_qb <= w_qa[RCP3125_A_SH+15:RCP3125_A_SH];
            r2_x1 <= r1_x1;
            r2_dp <= r1_dp;

            r3_rb  <= w_rem[11:0];
            r3_q25 <= w_q25[RCP25_SH+25:RCP25_SH];
            r3_p4  <= r2_p4;
            r3_qb  <= r2_qb;
            r3_dp  <= r2_dp;

            r4_x2  <= w_x2[27:0];
            r4_dq  <= w_dq[31:0];
            r4_veg <= ONE_Q30 - 31'(r3_p4) + 31'(r3_q25);

            r5_q2  <= w_q2[RCP3125_B_SH+16:RCP3125_B_SH];
            r5_dq  <= r4_dq;
            r5_veg <= r4_veg;

            r6_ab  <= w_ab[31:0];
            r6_veg <= r5_veg;

            r7_abc <= w_abc[61:30];

            r8_heat <= w_heat;
        end
    end

    assign o_valid          = r_v[Stages];
    assign o_soil_heat      = r8_heat;
    assign o_last_pixel_out = r_last[Stages];

    // An accepted request occupies the first stage in the next cycle.
    `SHF_ASSERT_NEXT(a_enter, i_clk, i_rst_n, i_valid && o_ready, r_v[1])
    // A request in the last inner stage reaches the output when not stalled.
    `SHF_ASSERT_NEXT(a_drain, i_clk, i_rst_n, r_v[Stages-1] && w_adv, o_valid)
    // The vegetation factor never exceeds one.
    `SHF_ASSERT_IMPLY(a_veg_max, i_clk, i_rst_n, r_v[4] && !r_neg[4], r4_veg <= ONE_Q30)

endmodule

`default_nettype wire
